@@ hdl/hct_pkg.sv @@
package hct_pkg;

  localparam int ChW    = 8;
  localparam int QW     = 16;
  localparam int RemW   = 11;
  localparam int Steps  = 4;
  localparam int DivStg = QW / Steps;

  localparam logic [2:0] RegRedHueBelow = 3'd0;
  localparam logic [2:0] RegRedHueAbove = 3'd1;
  localparam logic [2:0] RegRedSatMin   = 3'd2;
  localparam logic [2:0] RegRedValMin   = 3'd3;
  localparam logic [2:0] RegBlueHueMin  = 3'd4;
  localparam logic [2:0] RegBlueHueMax  = 3'd5;
  localparam logic [2:0] RegBlueSatMin  = 3'd6;
  localparam logic [2:0] RegBlueValMin  = 3'd7;

  typedef struct packed {
    logic [ChW-1:0] mx;
    logic           undef;
    logic           sat_full;
    logic           hue_zero;
  } side_t;

  typedef struct packed {
    logic [15:0] red_hue_below;
    logic [15:0] red_hue_above;
    logic [15:0] red_sat_min;
    logic [7:0]  red_val_min;
    logic [15:0] blue_hue_min;
    logic [15:0] blue_hue_max;
    logic [15:0] blue_sat_min;
    logic [7:0]  blue_val_min;
  } cfg_t;

endpackage

@@ hdl/hsv_color_threshold_top.sv @@
// hsv_color_threshold_top: per-pixel bgr to hsv conversion with red and blue masks.
// input channel in_valid/in_ready carries one pixel item (blue, green, red bytes).
// output channel out_valid/out_ready carries hue, saturation, brightness,
// hue_undefined and the red and blue mask bits for that pixel.
// thresholds are written through cfg_we/cfg_addr/cfg_wdata; the user must write them
// only while idle; the block itself does not enforce it. one stage finds max, min
// and the hue numerator, four stages run the two restoring dividers at four
// quotient bits each, and one stage applies the thresholds into the output register.
// throughput is one item per cycle unless the output stalls; pixels are independent.
// when out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
// reset clears all valid bits and loads the default thresholds.
module hsv_color_threshold_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_hue,
  output logic [15:0] out_saturation,
  output logic [7:0]  out_brightness,
  output logic        out_hue_undefined,
  output logic        out_red_mask,
  output logic        out_blue_mask,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import hct_pkg::*;

  cfg_t            cfg_r;
  logic            en;
  logic            v_r   [DivStg+1];
  side_t           side_r[DivStg+1];
  logic [RemW-1:0] h_rem [DivStg+1];
  logic [RemW-1:0] h_div [DivStg+1];
  logic [QW-1:0]   h_quo [DivStg+1];
  logic [RemW-1:0] s_rem [DivStg+1];
  logic [RemW-1:0] s_div [DivStg+1];
  logic [QW-1:0]   s_quo [DivStg+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_hue_below <= 16'd3277;
      cfg_r.red_hue_above <= 16'd62259;
      cfg_r.red_sat_min   <= 16'd26214;
      cfg_r.red_val_min   <= 8'd38;
      cfg_r.blue_hue_min  <= 16'd10923;
      cfg_r.blue_hue_max  <= 16'd45875;
      cfg_r.blue_sat_min  <= 16'd26214;
      cfg_r.blue_val_min  <= 8'd110;
    end else if (cfg_we) begin
      case (cfg_addr)
        RegRedHueBelow: cfg_r.red_hue_below <= cfg_wdata;
        RegRedHueAbove: cfg_r.red_hue_above <= cfg_wdata;
        RegRedSatMin:   cfg_r.red_sat_min   <= cfg_wdata;
        RegRedValMin:   cfg_r.red_val_min   <= cfg_wdata[7:0];
        RegBlueHueMin:  cfg_r.blue_hue_min  <= cfg_wdata;
        RegBlueHueMax:  cfg_r.blue_hue_max  <= cfg_wdata;
        RegBlueSatMin:  cfg_r.blue_sat_min  <= cfg_wdata;
        RegBlueValMin:  cfg_r.blue_val_min  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  hct_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_blue   (in_blue),
    .in_green  (in_green),
    .in_red    (in_red),
    .valid_r   (v_r[0]),
    .side_r    (side_r[0]),
    .hue_rem_r (h_rem[0]),
    .hue_div_r (h_div[0]),
    .sat_rem_r (s_rem[0]),
    .sat_div_r (s_div[0])
  );

  assign h_quo[0] = '0;
  assign s_quo[0] = '0;

  for (genvar k = 0; k < DivStg; k++) begin : g_div
    hct_div_stage u_hdiv (
      .clk    (clk),
      .en     (en),
      .rem_in (h_rem[k]),
      .div_in (h_div[k]),
      .quo_in (h_quo[k]),
      .rem_r  (h_rem[k+1]),
      .div_r  (h_div[k+1]),
      .quo_r  (h_quo[k+1])
    );
    hct_div_stage u_sdiv (
      .clk    (clk),
      .en     (en),
      .rem_in (s_rem[k]),
      .div_in (s_div[k]),
      .quo_in (s_quo[k]),
      .rem_r  (s_rem[k+1]),
      .div_r  (s_div[k+1]),
      .quo_r  (s_quo[k+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k+1] <= side_r[k];
      end
    end
  end

  hct_classify u_cls (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v_r[DivStg]),
    .side     (side_r[DivStg]),
    .hue_q    (h_quo[DivStg]),
    .sat_q    (s_quo[DivStg]),
    .cfg      (cfg_r),
    .valid_r  (out_valid),
    .hue_r    (out_hue),
    .sat_r    (out_saturation),
    .val_r    (out_brightness),
    .undef_r  (out_hue_undefined),
    .red_r    (out_red_mask),
    .blue_r   (out_blue_mask)
  );

endmodule

@@ hdl/hct_prep.sv @@
module hct_prep (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [hct_pkg::ChW-1:0]      in_blue,
  input  logic [hct_pkg::ChW-1:0]      in_green,
  input  logic [hct_pkg::ChW-1:0]      in_red,
  output logic                         valid_r,
  output hct_pkg::side_t               side_r,
  output logic [hct_pkg::RemW-1:0]     hue_rem_r,
  output logic [hct_pkg::RemW-1:0]     hue_div_r,
  output logic [hct_pkg::RemW-1:0]     sat_rem_r,
  output logic [hct_pkg::RemW-1:0]     sat_div_r
);
  import hct_pkg::*;

  logic [ChW-1:0]  mx, mn, d;
  logic [RemW-1:0] d_w, d6, n;

  always_comb begin
    mx = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx) mx = in_blue;
    mn = in_red;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;
    d   = mx - mn;
    d_w = {{(RemW-ChW){1'b0}}, d};
    d6  = (d_w << 2) + (d_w << 1);
    if (in_red == mx) begin
      if (in_green >= in_blue) begin
        n = {{(RemW-ChW){1'b0}}, in_green - in_blue};
      end else begin
        n = d6 - {{(RemW-ChW){1'b0}}, in_blue - in_green};
      end
    end else if (in_green == mx) begin
      n = (d_w << 1) + {{(RemW-ChW){1'b0}}, in_blue} - {{(RemW-ChW){1'b0}}, in_red};
    end else begin
      n = (d_w << 2) + {{(RemW-ChW){1'b0}}, in_red} - {{(RemW-ChW){1'b0}}, in_green};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r.mx       <= mx;
      side_r.undef    <= (mx == '0);
      side_r.sat_full <= (d == mx);
      side_r.hue_zero <= (d == '0);
      hue_rem_r       <= n;
      hue_div_r       <= d6;
      sat_rem_r       <= d_w;
      sat_div_r       <= {{(RemW-ChW){1'b0}}, mx};
    end
  end

endmodule

@@ hdl/hct_div_stage.sv @@
module hct_div_stage (
  input  logic                      clk,
  input  logic                      en,
  input  logic [hct_pkg::RemW-1:0]  rem_in,
  input  logic [hct_pkg::RemW-1:0]  div_in,
  input  logic [hct_pkg::QW-1:0]    quo_in,
  output logic [hct_pkg::RemW-1:0]  rem_r,
  output logic [hct_pkg::RemW-1:0]  div_r,
  output logic [hct_pkg::QW-1:0]    quo_r
);
  import hct_pkg::*;

  logic [RemW-1:0] rem_nxt;
  logic [QW-1:0]   quo_nxt;
  logic [RemW:0]   t;

  // restoring division, Steps quotient bits per stage
  always_comb begin
    rem_nxt = rem_in;
    quo_nxt = quo_in;
    t       = '0;
    for (int i = 0; i < Steps; i++) begin
      t = {rem_nxt, 1'b0};
      if (t >= {1'b0, div_in}) begin
        t       = t - {1'b0, div_in};
        quo_nxt = {quo_nxt[QW-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_nxt[QW-2:0], 1'b0};
      end
      rem_nxt = t[RemW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      div_r <= div_in;
      quo_r <= quo_nxt;
    end
  end

endmodule

@@ hdl/hct_classify.sv @@
module hct_classify (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  hct_pkg::side_t            side,
  input  logic [hct_pkg::QW-1:0]    hue_q,
  input  logic [hct_pkg::QW-1:0]    sat_q,
  input  hct_pkg::cfg_t             cfg,
  output logic                      valid_r,
  output logic [15:0]               hue_r,
  output logic [15:0]               sat_r,
  output logic [7:0]                val_r,
  output logic                      undef_r,
  output logic                      red_r,
  output logic                      blue_r
);
  import hct_pkg::*;

  logic [15:0] hue, sat;
  logic        redm, bluem;

  always_comb begin
    hue = (side.undef || side.hue_zero) ? '0 : hue_q;
    if (side.undef) begin
      sat = '0;
    end else if (side.sat_full) begin
      sat = '1;
    end else begin
      sat = sat_q;
    end
    redm  = !side.undef && (hue < cfg.red_hue_below || hue > cfg.red_hue_above) &&
            sat > cfg.red_sat_min && side.mx > cfg.red_val_min;
    bluem = !side.undef && hue > cfg.blue_hue_min && hue < cfg.blue_hue_max &&
            sat > cfg.blue_sat_min && side.mx > cfg.blue_val_min;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r   <= hue;
      sat_r   <= sat;
      val_r   <= side.mx;
      undef_r <= side.undef;
      red_r   <= redm;
      blue_r  <= bluem;
    end
  end

endmodule

@@ dv/tb_hsv_color_threshold_top.sv @@
`timescale 1ns / 1ps

module tb_hsv_color_threshold_top;
  import hct_pkg::*;

  typedef struct {
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [7:0]  brightness;
    logic        hue_undefined;
    logic        red_mask;
    logic        blue_mask;
  } pixel_hsv_t;

  class hsv_scoreboard;
    logic [15:0] thr [8];
    pixel_hsv_t  pending [$];
    int          errors;
    int          checked;

    function new();
      errors = 0;
      checked = 0;
      load_defaults();
    endfunction

    function void load_defaults();
      thr[RegRedHueBelow] = 16'd3277;
      thr[RegRedHueAbove] = 16'd62259;
      thr[RegRedSatMin]   = 16'd26214;
      thr[RegRedValMin]   = 16'd38;
      thr[RegBlueHueMin]  = 16'd10923;
      thr[RegBlueHueMax]  = 16'd45875;
      thr[RegBlueSatMin]  = 16'd26214;
      thr[RegBlueValMin]  = 16'd110;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      if (idx == RegRedValMin || idx == RegBlueValMin) thr[idx] = {8'd0, val[7:0]};
      else thr[idx] = val;
    endfunction

    function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      pixel_hsv_t  e;
      int          mx, mn, d, n;
      longint      q;
      mx = int'(r); mn = int'(r);
      if (int'(g) > mx) mx = int'(g);
      if (int'(b) > mx) mx = int'(b);
      if (int'(g) < mn) mn = int'(g);
      if (int'(b) < mn) mn = int'(b);
      d = mx - mn;
      e.hue = 0; e.saturation = 0; e.hue_undefined = 0;
      e.red_mask = 0; e.blue_mask = 0;
      e.brightness = mx[7:0];
      if (mx == 0) begin
        e.hue_undefined = 1;
      end else begin
        q = (longint'(d) << 16) / mx;
        e.saturation = (q > 65535) ? 16'hffff : q[15:0];
        if (d != 0) begin
          if (int'(r) == mx) begin
            n = int'(g) - int'(b);
            if (n < 0) n += 6 * d;
          end else if (int'(g) == mx) begin
            n = 2 * d + int'(b) - int'(r);
          end else begin
            n = 4 * d + int'(r) - int'(g);
          end
          q = (longint'(n) << 16) / (6 * d);
          e.hue = (q > 65535) ? 16'hffff : q[15:0];
        end
        e.red_mask = (e.hue < thr[RegRedHueBelow] || e.hue > thr[RegRedHueAbove]) &&
                     e.saturation > thr[RegRedSatMin] && mx > thr[RegRedValMin];
        e.blue_mask = e.hue > thr[RegBlueHueMin] && e.hue < thr[RegBlueHueMax] &&
                      e.saturation > thr[RegBlueSatMin] && mx > thr[RegBlueValMin];
      end
      pending = {pending, e};
    endfunction

    function void check_result(pixel_hsv_t a);
      pixel_hsv_t e;
      if (pending.size() == 0) begin
        $error("result with no pixel pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.hue !== e.hue) begin
        $error("hue exp %0d got %0d", e.hue, a.hue); errors++;
      end
      if (a.saturation !== e.saturation) begin
        $error("saturation exp %0d got %0d", e.saturation, a.saturation); errors++;
      end
      if (a.brightness !== e.brightness) begin
        $error("brightness exp %0d got %0d", e.brightness, a.brightness); errors++;
      end
      if (a.hue_undefined !== e.hue_undefined) begin
        $error("hue_undefined exp %0d got %0d", e.hue_undefined, a.hue_undefined); errors++;
      end
      if (a.red_mask !== e.red_mask) begin
        $error("red_mask exp %0d got %0d", e.red_mask, a.red_mask); errors++;
      end
      if (a.blue_mask !== e.blue_mask) begin
        $error("blue_mask exp %0d got %0d", e.blue_mask, a.blue_mask); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [7:0]  in_blue = 0, in_green = 0, in_red = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [15:0] out_hue, out_saturation;
  logic [7:0]  out_brightness;
  logic        out_hue_undefined, out_red_mask, out_blue_mask;
  logic        cfg_we = 0;
  logic [2:0]  cfg_addr = 0;
  logic [15:0] cfg_wdata = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int pixels_sent = 0;
  hsv_scoreboard sb;

  hsv_color_threshold_top dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    #20ms;
    $display("[hsv_color_threshold_top] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    pixel_hsv_t a;
    if (rst_n && out_valid && out_ready) begin
      a.hue = out_hue; a.saturation = out_saturation; a.brightness = out_brightness;
      a.hue_undefined = out_hue_undefined; a.red_mask = out_red_mask;
      a.blue_mask = out_blue_mask;
      sb.check_result(a);
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_blue <= b; in_green <= g; in_red <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(b, g, r);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic write_thr(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic random_pixel();
    logic [7:0] b, g, r, base;
    case ($urandom_range(5))
      0: begin
        base = 8'($urandom);
        b = base; g = base; r = base;
      end
      1: begin
        r = 8'hff; g = 8'($urandom_range(40)); b = 8'($urandom_range(40));
        if ($urandom_range(1)) begin
          g = b; b = 8'($urandom_range(80));
        end
      end
      2: begin
        b = 8'($urandom_range(255, 110)); g = 8'($urandom_range(60));
        r = 8'($urandom_range(60));
      end
      3: begin
        base = 8'($urandom); b = base; g = base; r = 8'($urandom);
        if ($urandom_range(1)) begin
          r = base; g = 8'($urandom);
        end
      end
      default: begin
        b = 8'($urandom); g = 8'($urandom); r = 8'($urandom);
      end
    endcase
    send_pixel(b, g, r);
  endtask

  task automatic random_thresholds();
    for (int i = 0; i < 8; i++) write_thr(i[2:0], 16'($urandom));
  endtask

  initial begin
    sb = new();
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(1, 1, 1);
    send_pixel(128, 128, 128);
    send_pixel(0, 0, 255);
    send_pixel(0, 255, 0);
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 255);
    send_pixel(255, 0, 255);
    send_pixel(255, 255, 0);
    send_pixel(1, 0, 255);
    send_pixel(12, 0, 255);
    send_pixel(0, 12, 255);
    send_pixel(200, 0, 39);
    send_pixel(255, 20, 20);
    send_pixel(111, 10, 10);
    send_pixel(110, 10, 10);
    send_pixel(0, 0, 39);
    send_pixel(0, 0, 38);
    send_pixel(170, 85, 85);
    send_pixel(254, 1, 127);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 71 : 0;
      recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 29 : 0;
      case (phase)
        0: for (int i = 0; i < 8; i++) write_thr(i[2:0], 16'h0000);
        1: for (int i = 0; i < 8; i++) write_thr(i[2:0], 16'hffff);
        default: random_thresholds();
      endcase
      repeat (60) random_pixel();
      drain();
      random_thresholds();
      repeat (60) random_pixel();
      drain();
    end
    write_thr(RegRedHueBelow, 16'd3277);
    write_thr(RegRedHueAbove, 16'd62259);
    write_thr(RegRedSatMin, 16'd26214);
    write_thr(RegRedValMin, 16'd38);
    write_thr(RegBlueHueMin, 16'd10923);
    write_thr(RegBlueHueMax, 16'd45875);
    write_thr(RegBlueSatMin, 16'd26214);
    write_thr(RegBlueValMin, 16'd110);
    repeat (70) random_pixel();
    drain();

    $display("pixels sent %0d, results checked %0d, threshold sets incl zero/full",
             pixels_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[hsv_color_threshold_top] OK");
    end else begin
      $display("[hsv_color_threshold_top] ERROR");
    end
    $finish;
  end
endmodule
